FILE: design/nlfc_pkg.sv
// Shared constants, types and the hex digit decoder for the line framer/checker.
// No dependencies; used by every module of the block.
package nlfc_pkg;

  localparam int BYTE_W            = 8;
  localparam int LEN_W             = 7;
  localparam int LINE_CAPACITY_DEF = 128;
  localparam int MIN_SENTENCE_LEN  = 4;

  localparam logic [BYTE_W-1:0] CHAR_LF     = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_CR     = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_TAB    = 8'h09;
  localparam logic [BYTE_W-1:0] CHAR_SPACE  = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] CHAR_PLUS   = 8'h2B;
  localparam logic [BYTE_W-1:0] CHAR_MINUS  = 8'h2D;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_digit_t;

  typedef struct packed {
    logic              valid;
    logic [LEN_W-1:0]  length;
    logic              overflow;
    logic [BYTE_W-1:0] checksum;
  } result_t;

  function automatic hex_digit_t hex_digit(input logic [BYTE_W-1:0] c);
    hex_digit_t d;
    d.ok  = 1'b1;
    d.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d.val = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d.val = 4'(c - 8'h61 + 8'd10);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d.val = 4'(c - 8'h41 + 8'd10);
    end else begin
      d.ok = 1'b0;
    end
    return d;
  endfunction

endpackage

FILE: design/nlfc_sum_check.sv
// Compares the two trailing checksum characters, read as base-16 text, with a sum.
// Depends on nlfc_pkg.
module nlfc_sum_check (
  input  logic [nlfc_pkg::BYTE_W-1:0] c0,
  input  logic [nlfc_pkg::BYTE_W-1:0] c1,
  input  logic [nlfc_pkg::BYTE_W-1:0] sum,
  output logic                        match
);

  nlfc_pkg::hex_digit_t h0;
  nlfc_pkg::hex_digit_t h1;
  logic                 c0_space;
  logic [3:0]           v1;

  assign h0       = nlfc_pkg::hex_digit(c0);
  assign h1       = nlfc_pkg::hex_digit(c1);
  assign c0_space = (c0 == nlfc_pkg::CHAR_SPACE) ||
                    (c0 >= nlfc_pkg::CHAR_TAB && c0 <= nlfc_pkg::CHAR_CR);
  assign v1       = h1.ok ? h1.val : 4'd0;

  always_comb begin
    if (c0_space || c0 == nlfc_pkg::CHAR_PLUS) begin
      match = (sum == {4'd0, v1});
    end else if (c0 == nlfc_pkg::CHAR_MINUS) begin
      match = (sum == '0) && (v1 == 4'd0);
    end else if (h0.ok) begin
      match = h1.ok ? (sum == {h0.val, h1.val}) : (sum == {4'd0, h0.val});
    end else begin
      match = (sum == '0);
    end
  end

endmodule

FILE: design/nlfc_framer.sv
// Line state (count, running XOR, last four bytes, leading '$') and per-byte result.
// Depends on nlfc_pkg and nlfc_sum_check.
module nlfc_framer #(
  parameter int LINE_CAPACITY = nlfc_pkg::LINE_CAPACITY_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic [nlfc_pkg::BYTE_W-1:0] data,
  input  logic                        check_mode,
  output nlfc_pkg::result_t           result
);

  localparam int CNT_W = $clog2(LINE_CAPACITY + 1);

  logic [CNT_W-1:0]           pending_count;
  logic [CNT_W-1:0]           pending_count_next;
  logic [nlfc_pkg::BYTE_W-1:0] running_xor;
  logic [nlfc_pkg::BYTE_W-1:0] running_xor_next;
  logic [nlfc_pkg::BYTE_W-1:0] recent_bytes [4];
  logic                        starts_with_dollar;
  logic                        starts_with_dollar_next;

  logic                        is_lf;
  logic                        cr;
  logic [CNT_W-1:0]            len;
  logic                        long_enough;
  logic [nlfc_pkg::BYTE_W-1:0] sum;
  logic [nlfc_pkg::BYTE_W-1:0] c0;
  logic [nlfc_pkg::BYTE_W-1:0] c1;
  logic                        match;
  logic [CNT_W-1:0]            count_inc;
  logic                        full;

  assign is_lf       = (data == nlfc_pkg::CHAR_LF);
  assign cr          = (pending_count != '0) && (recent_bytes[0] == nlfc_pkg::CHAR_CR);
  assign len         = cr ? pending_count - CNT_W'(1) : pending_count;
  assign long_enough = (len >= CNT_W'(nlfc_pkg::MIN_SENTENCE_LEN));
  assign sum         = running_xor ^ recent_bytes[0] ^ recent_bytes[1] ^ recent_bytes[2] ^
                       (cr ? recent_bytes[3] : '0);
  assign c1          = cr ? recent_bytes[1] : recent_bytes[0];
  assign c0          = cr ? recent_bytes[2] : recent_bytes[1];
  assign count_inc   = pending_count + CNT_W'(1);
  assign full        = (count_inc == CNT_W'(LINE_CAPACITY));

  nlfc_sum_check u_sum_check (
    .c0    (c0),
    .c1    (c1),
    .sum   (sum),
    .match (match)
  );

  always_comb begin
    result.valid    = 1'b0;
    result.length   = '0;
    result.overflow = 1'b0;
    result.checksum = '0;
    if (is_lf) begin
      result.valid    = (len != '0) &&
                        (!check_mode || (long_enough && starts_with_dollar && match));
      result.length   = nlfc_pkg::LEN_W'(len);
      result.checksum = long_enough ? sum : '0;
    end else if (full) begin
      result.valid    = 1'b1;
      result.overflow = 1'b1;
    end
  end

  always_comb begin
    pending_count_next      = count_inc;
    running_xor_next        = running_xor;
    starts_with_dollar_next = starts_with_dollar;
    if (pending_count == '0) begin
      starts_with_dollar_next = (data == nlfc_pkg::CHAR_DOLLAR);
    end else begin
      running_xor_next = running_xor ^ data;
    end
    if (is_lf || full) begin
      pending_count_next      = '0;
      running_xor_next        = '0;
      starts_with_dollar_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_count      <= '0;
      running_xor        <= '0;
      starts_with_dollar <= 1'b0;
      recent_bytes[0]    <= '0;
      recent_bytes[1]    <= '0;
      recent_bytes[2]    <= '0;
      recent_bytes[3]    <= '0;
    end else if (step) begin
      pending_count      <= pending_count_next;
      running_xor        <= running_xor_next;
      starts_with_dollar <= starts_with_dollar_next;
      if (!is_lf) begin
        recent_bytes[3] <= recent_bytes[2];
        recent_bytes[2] <= recent_bytes[1];
        recent_bytes[1] <= recent_bytes[0];
        recent_bytes[0] <= data;
      end
    end
  end

endmodule

FILE: design/nmea_line_framer_checker_core.sv
// Top level of the NMEA line framer and checksum checker: input register,
// framer, result register and mode register. Depends on nlfc_pkg and nlfc_framer.
//
//   channel | handshake            | payload
//   --------+----------------------+-----------------------------------------
//   cfg     | cfg_valid/cfg_ready  | cfg_data (check_mode)
//   in      | in_valid/in_stall    | rx_byte
//   out     | out_valid/out_stall  | line_length, overflow, sentence_checksum
//
// One byte per cycle sustained while the output is not stalled; a taken byte's result
// passes the input register, then the framer logic and the result register.
// The input register doubles as a skid stage: a byte is taken while a result
// waits, and in_stall rises only when both registers are held.
// Synchronous reset clears the line state, the mode and both valid flags.
// cfg_ready is always high.
module nmea_line_framer_checker_core #(
  parameter int LINE_CAPACITY = nlfc_pkg::LINE_CAPACITY_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [nlfc_pkg::BYTE_W-1:0] rx_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [nlfc_pkg::LEN_W-1:0]  line_length,
  output logic                        overflow,
  output logic [nlfc_pkg::BYTE_W-1:0] sentence_checksum
);

  logic                        check_mode;
  logic                        in_reg_valid;
  logic [nlfc_pkg::BYTE_W-1:0] in_reg_byte;
  logic                        advance;
  logic                        step;
  logic                        in_take;
  nlfc_pkg::result_t           result;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid || !out_stall;
  assign step      = in_reg_valid && advance;
  assign in_stall  = in_reg_valid && !advance;
  assign in_take   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      check_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      check_mode <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_take) begin
      in_reg_valid <= 1'b1;
    end else if (step) begin
      in_reg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_reg_byte <= rx_byte;
    end
  end

  nlfc_framer #(
    .LINE_CAPACITY (LINE_CAPACITY)
  ) u_framer (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .data       (in_reg_byte),
    .check_mode (check_mode),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= step && result.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      line_length       <= result.length;
      overflow          <= result.overflow;
      sentence_checksum <= result.checksum;
    end
  end

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (in_reg_valid && out_valid && out_stall))
    else $error("input stalled while a register is free");

  a_overflow_payload: assert property (@(posedge clk) disable iff (rst)
    (out_valid && overflow) |-> (line_length == '0 && sentence_checksum == '0))
    else $error("overflow result carries a length or checksum");

  a_held_byte_kept: assert property (@(posedge clk) disable iff (rst)
    in_stall |=> (in_reg_valid && $stable(in_reg_byte)))
    else $error("held input byte lost during output stall");

endmodule

FILE: bench/nmea_line_framer_checker_core_test.sv
// Self-checking bench for nmea_line_framer_checker_core: directed and random byte streams
// with random idling on both channels, checked against a line-framing scoreboard class.
// Depends on nlfc_pkg and the core RTL.
module nmea_line_framer_checker_core_test;

  localparam bit MODE_PLAIN = 1'b0;
  localparam bit MODE_CHECK = 1'b1;
  localparam logic [nlfc_pkg::BYTE_W-1:0] CHAR_STAR = 8'h2A;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 8;
  localparam int LONG_HOLD_CYCLES = 80;
  localparam int PHASE_ITEMS = 65;

  typedef struct packed {
    logic [nlfc_pkg::LEN_W-1:0]  length;
    logic                        overflow;
    logic [nlfc_pkg::BYTE_W-1:0] checksum;
  } line_result_t;

  class line_scoreboard;
    bit mode;
    int unsigned pending;
    logic [nlfc_pkg::BYTE_W-1:0] run_xor;
    logic [nlfc_pkg::BYTE_W-1:0] recent [4];
    bit dollar;
    line_result_t expected_q [$];
    int errors;

    function new();
      mode = MODE_PLAIN;
      pending = 0;
      run_xor = '0;
      dollar = 1'b0;
      errors = 0;
      foreach (recent[i]) recent[i] = '0;
    endfunction

    function int nibble(logic [nlfc_pkg::BYTE_W-1:0] c);
      if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
      if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
      if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
      return -1;
    endfunction

    function bit blank(logic [nlfc_pkg::BYTE_W-1:0] c);
      return c == nlfc_pkg::CHAR_SPACE ||
             (c >= nlfc_pkg::CHAR_TAB && c <= nlfc_pkg::CHAR_CR);
    endfunction

    function int read_two(logic [nlfc_pkg::BYTE_W-1:0] c0, logic [nlfc_pkg::BYTE_W-1:0] c1);
      int h0;
      int h1;
      h0 = nibble(c0);
      h1 = nibble(c1);
      if (blank(c0) || c0 == nlfc_pkg::CHAR_PLUS) return (h1 < 0) ? 0 : h1;
      if (c0 == nlfc_pkg::CHAR_MINUS) return (h1 < 0) ? 0 : -h1;
      if (h0 < 0) return 0;
      if (h1 < 0) return h0;
      return h0 * 16 + h1;
    endfunction

    function void clear_line();
      pending = 0;
      run_xor = '0;
      dollar = 1'b0;
    endfunction

    function void note_byte(logic [nlfc_pkg::BYTE_W-1:0] c);
      bit cr;
      bit ok;
      int unsigned len;
      logic [nlfc_pkg::BYTE_W-1:0] sum;
      logic [nlfc_pkg::BYTE_W-1:0] c0;
      logic [nlfc_pkg::BYTE_W-1:0] c1;
      line_result_t r;
      if (c == nlfc_pkg::CHAR_LF) begin
        cr = pending > 0 && recent[0] == nlfc_pkg::CHAR_CR;
        len = cr ? pending - 1 : pending;
        sum = '0;
        ok = 1'b0;
        if (len >= nlfc_pkg::MIN_SENTENCE_LEN) begin
          sum = run_xor ^ recent[0] ^ recent[1] ^ recent[2];
          if (cr) sum ^= recent[3];
          c1 = cr ? recent[1] : recent[0];
          c0 = cr ? recent[2] : recent[1];
          ok = dollar && read_two(c0, c1) == int'(sum);
        end
        clear_line();
        if (len != 0 && (mode == MODE_PLAIN || ok)) begin
          r.length = len[nlfc_pkg::LEN_W-1:0];
          r.overflow = 1'b0;
          r.checksum = sum;
          expected_q.push_back(r);
        end
        return;
      end
      if (pending == 0) dollar = (c == nlfc_pkg::CHAR_DOLLAR);
      else run_xor ^= c;
      recent[3] = recent[2];
      recent[2] = recent[1];
      recent[1] = recent[0];
      recent[0] = c;
      pending++;
      if (pending >= nlfc_pkg::LINE_CAPACITY_DEF) begin
        clear_line();
        r.length = '0;
        r.overflow = 1'b1;
        r.checksum = '0;
        expected_q.push_back(r);
      end
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(line_result_t got);
      line_result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result length=%0d overflow=%0b checksum=%02h",
                         got.length, got.overflow, got.checksum));
        return;
      end
      want = expected_q.pop_front();
      if (got.length !== want.length)
        report($sformatf("line_length %0d, want %0d", got.length, want.length));
      if (got.overflow !== want.overflow)
        report($sformatf("overflow %0b, want %0b", got.overflow, want.overflow));
      if (got.checksum !== want.checksum)
        report($sformatf("sentence_checksum %02h, want %02h", got.checksum, want.checksum));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  logic cfg_valid;
  logic cfg_ready;
  logic cfg_data;
  logic in_valid;
  logic in_stall;
  logic [nlfc_pkg::BYTE_W-1:0] rx_byte;
  logic out_valid;
  logic out_stall;
  logic [nlfc_pkg::LEN_W-1:0] line_length;
  logic overflow;
  logic [nlfc_pkg::BYTE_W-1:0] sentence_checksum;

  line_scoreboard sb;
  int send_pct;
  int recv_pct;
  bit long_hold_req;
  int hold_left;
  int unsigned cycles;
  logic [nlfc_pkg::BYTE_W-1:0] line_q [$];

  logic [nlfc_pkg::BYTE_W-1:0] directed [24] = '{
    8'h00, 8'hFF, nlfc_pkg::CHAR_LF,
    nlfc_pkg::CHAR_CR, nlfc_pkg::CHAR_LF,
    nlfc_pkg::CHAR_CR, nlfc_pkg::CHAR_CR, nlfc_pkg::CHAR_LF,
    nlfc_pkg::CHAR_DOLLAR, "A", "0", "0", nlfc_pkg::CHAR_CR, nlfc_pkg::CHAR_LF,
    nlfc_pkg::CHAR_DOLLAR, "Z", nlfc_pkg::CHAR_MINUS, "5", nlfc_pkg::CHAR_LF,
    nlfc_pkg::CHAR_DOLLAR, nlfc_pkg::CHAR_SPACE, "7", "a", nlfc_pkg::CHAR_LF
  };

  nmea_line_framer_checker_core dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .line_length(line_length),
    .overflow(overflow),
    .sentence_checksum(sentence_checksum)
  );

  always #10 clk = ~clk;

  always @(negedge clk) begin
    if (long_hold_req) begin
      hold_left = LONG_HOLD_CYCLES;
      long_hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("nmea_line_framer_checker_core verification failed");
      $finish;
    end
    if (!rst && out_valid && !out_stall)
      sb.check_result({line_length, overflow, sentence_checksum});
  end

  task send_byte(input logic [nlfc_pkg::BYTE_W-1:0] b);
    @(negedge clk);
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_byte(b);
  endtask

  task send_line();
    foreach (line_q[i]) send_byte(line_q[i]);
  endtask

  task quiesce();
    @(negedge clk) in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task write_mode(input bit m);
    quiesce();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.mode = m;
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  function logic [nlfc_pkg::BYTE_W-1:0] any_char();
    logic [nlfc_pkg::BYTE_W-1:0] v;
    v = 8'($urandom_range(255));
    while (v == nlfc_pkg::CHAR_LF) v = 8'($urandom_range(255));
    return v;
  endfunction

  function logic [nlfc_pkg::BYTE_W-1:0] text_char();
    if ($urandom_range(4) == 0) return any_char();
    return 8'($urandom_range(8'h7E, 8'h20));
  endfunction

  function logic [nlfc_pkg::BYTE_W-1:0] hex_char(logic [3:0] n);
    if (n < 10) return 8'h30 + n;
    return ($urandom_range(1) ? 8'h41 : 8'h61) + n - 8'd10;
  endfunction

  function logic [nlfc_pkg::BYTE_W-1:0] nonhex_char();
    case ($urandom_range(3))
      0: return CHAR_STAR;
      1: return 8'($urandom_range(8'h5A, 8'h47));
      2: return 8'($urandom_range(8'h7A, 8'h67));
      default: return nlfc_pkg::CHAR_DOLLAR;
    endcase
  endfunction

  function logic [nlfc_pkg::BYTE_W-1:0] blank_char();
    case ($urandom_range(3))
      0: return nlfc_pkg::CHAR_SPACE;
      1: return nlfc_pkg::CHAR_TAB;
      2: return nlfc_pkg::CHAR_CR;
      default: return 8'($urandom_range(8'h0C, 8'h0B));
    endcase
  endfunction

  task build_sentence();
    int n;
    logic [nlfc_pkg::BYTE_W-1:0] s;
    logic [nlfc_pkg::BYTE_W-1:0] c0;
    logic [nlfc_pkg::BYTE_W-1:0] c1;
    logic [nlfc_pkg::BYTE_W-1:0] b;
    line_q = {};
    line_q.push_back(nlfc_pkg::CHAR_DOLLAR);
    s = '0;
    n = ($urandom_range(3) == 0) ? $urandom_range(2) : $urandom_range(14);
    repeat (n) begin
      b = text_char();
      s ^= b;
      line_q.push_back(b);
    end
    line_q.push_back(($urandom_range(7) == 0) ? text_char() : CHAR_STAR);
    c0 = hex_char(s[7:4]);
    c1 = hex_char(s[3:0]);
    if (s < 16) begin
      case ($urandom_range(5))
        0: begin
          c0 = blank_char();
          c1 = hex_char(s[3:0]);
        end
        1: begin
          c0 = nlfc_pkg::CHAR_PLUS;
          c1 = hex_char(s[3:0]);
        end
        2: begin
          c0 = hex_char(s[3:0]);
          c1 = nonhex_char();
        end
        default: ;
      endcase
    end
    if (s == 0) begin
      case ($urandom_range(3))
        0: begin
          c0 = nlfc_pkg::CHAR_MINUS;
          c1 = 8'h30;
        end
        1: begin
          c0 = nonhex_char();
          c1 = text_char();
        end
        2: begin
          c0 = blank_char();
          c1 = nonhex_char();
        end
        default: ;
      endcase
    end
    line_q.push_back(c0);
    line_q.push_back(c1);
    if ($urandom_range(9) == 0) line_q[$urandom_range(line_q.size() - 1)] = any_char();
    if ($urandom_range(1)) line_q.push_back(nlfc_pkg::CHAR_CR);
    line_q.push_back(nlfc_pkg::CHAR_LF);
  endtask

  task build_noise();
    int n;
    line_q = {};
    n = $urandom_range(10);
    repeat (n) begin
      case ($urandom_range(9))
        0: line_q.push_back(nlfc_pkg::CHAR_CR);
        1: line_q.push_back(nlfc_pkg::CHAR_DOLLAR);
        default: line_q.push_back(any_char());
      endcase
    end
    if ($urandom_range(1)) line_q.push_back(nlfc_pkg::CHAR_CR);
    line_q.push_back(nlfc_pkg::CHAR_LF);
  endtask

  task build_raw();
    int n;
    line_q = {};
    n = $urandom_range(6, 1);
    repeat (n) line_q.push_back(8'($urandom_range(255)));
  endtask

  task build_long(input int n, input bit with_cr);
    line_q = {};
    repeat (n) line_q.push_back(any_char());
    if (with_cr) line_q.push_back(nlfc_pkg::CHAR_CR);
    line_q.push_back(nlfc_pkg::CHAR_LF);
  endtask

  task build_random_line();
    int k;
    k = $urandom_range(99);
    if (k < 60) build_sentence();
    else if (k < 78) build_noise();
    else if (k < 96) build_raw();
    else begin
      case ($urandom_range(3))
        0: build_long(nlfc_pkg::LINE_CAPACITY_DEF - 1, 1'b0);
        1: build_long(nlfc_pkg::LINE_CAPACITY_DEF, 1'b0);
        2: build_long(nlfc_pkg::LINE_CAPACITY_DEF - 2, 1'b1);
        default: build_long($urandom_range(200, nlfc_pkg::LINE_CAPACITY_DEF + 1), 1'b0);
      endcase
    end
  endtask

  task run_phase(input bit m, input int sp, input int rp, input bit forced_long,
                 input bit pressure);
    int count;
    send_pct = sp;
    recv_pct = rp;
    write_mode(m);
    count = 0;
    if (forced_long) begin
      build_long(nlfc_pkg::LINE_CAPACITY_DEF - 1, 1'b0);
      send_line();
      build_long(nlfc_pkg::LINE_CAPACITY_DEF, 1'b0);
      send_line();
    end
    if (pressure) long_hold_req = 1'b1;
    while (count < PHASE_ITEMS) begin
      build_random_line();
      send_line();
      count += line_q.size();
    end
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = 1'b0;
    in_valid = 1'b0;
    rx_byte = '0;
    out_stall = 1'b0;
    send_pct = 0;
    recv_pct = 0;
    long_hold_req = 1'b0;
    hold_left = 0;
    cycles = 0;
    repeat (11) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    foreach (directed[i]) send_byte(directed[i]);

    run_phase(MODE_CHECK, 34, 46, 1'b0, 1'b0);
    run_phase(MODE_PLAIN, 34, 46, 1'b1, 1'b0);
    run_phase(MODE_CHECK, 46, 34, 1'b0, 1'b0);
    run_phase(MODE_PLAIN, 46, 34, 1'b0, 1'b0);
    run_phase(MODE_CHECK, 0, 0, 1'b0, 1'b0);
    run_phase(MODE_PLAIN, 0, 0, 1'b0, 1'b1);
    quiesce();

    if (sb.errors == 0) begin
      $display("nmea_line_framer_checker_core verification clean");
    end else begin
      $display("nmea_line_framer_checker_core verification failed");
    end
    $finish;
  end
endmodule
